// ----- design/mnd_pkg.sv -----
// ----------------------------------------------------------------------------
// mnd_pkg
// shared types, register codes, widths and saturation helper for the
// miyamoto-nagai disk force pipeline
// ----------------------------------------------------------------------------
package mnd_pkg;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_SCALE_LENGTH = 3'd0;
    localparam logic [2:0] REG_SCALE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DISK_MASS    = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
    localparam logic [2:0] REG_CENTER_X     = 3'd4;
    localparam logic [2:0] REG_CENTER_Y     = 3'd5;
    localparam logic [2:0] REG_CENTER_Z     = 3'd6;
    localparam logic [2:0] REG_MIN_LEVEL    = 3'd7;

    // integer square root: 70-bit radicand, 35-bit root, one bit per stage
    localparam int SQRT_IN_W  = 70;
    localparam int SQRT_OUT_W = 35;
    localparam int SQRT_LAT   = SQRT_OUT_W;

    // divider: overflow check stage, then one quotient bit per stage
    localparam int DIV_W   = 137;
    localparam int DIV_Q_W = 31;
    localparam int DIV_LAT = DIV_Q_W + 1;

    typedef struct packed {
        logic [31:0]        particle_tag;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [4:0]         step_level;
    } particle_t;

    typedef struct packed {
        logic [31:0]        tag_out;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic signed [31:0] potential;
    } result_t;

    // magnitude q (ovf means q >= 2^31) to saturated two's complement
    function automatic logic [31:0] sat_mag(input logic [DIV_Q_W-1:0] q,
                                            input logic ovf,
                                            input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = ovf ? 32'h8000_0000 : (32'd0 - {1'b0, q});
        end
        else
        begin
            r = ovf ? 32'h7FFF_FFFF : {1'b0, q};
        end
        return r;
    endfunction

endpackage

// ----- design/mnd_isqrt.sv -----
// ----------------------------------------------------------------------------
// mnd_isqrt
// pipelined floor square root, one root bit resolved per stage
// ----------------------------------------------------------------------------
module mnd_isqrt import mnd_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [SQRT_IN_W-1:0]  radicand,
    output logic [SQRT_OUT_W-1:0] root
);

    localparam int RW = SQRT_IN_W + 2;

    logic [RW-1:0]         rem_reg  [SQRT_OUT_W-1];
    logic [SQRT_OUT_W-1:0] root_reg [SQRT_OUT_W];

    for (genvar k = 0; k < SQRT_OUT_W; k++)
    begin : g_stage
        localparam int BIT = SQRT_OUT_W - 1 - k;
        logic [RW-1:0]         rem_in;
        logic [RW-1:0]         trial;
        logic [SQRT_OUT_W-1:0] root_in;
        logic                  take;

        if (k == 0)
        begin : g_first
            assign rem_in  = RW'(radicand);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign trial = (RW'(root_in) << (BIT + 1)) + (RW'(1) << (2 * BIT));
        assign take  = (trial <= rem_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= take ? (root_in | (SQRT_OUT_W'(1) << BIT)) : root_in;
            end
        end

        if (k < SQRT_OUT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[SQRT_OUT_W-1];

endmodule

// ----- design/mnd_divider.sv -----
// ----------------------------------------------------------------------------
// mnd_divider
// pipelined restoring divider with a saturation flag for quotients >= 2^31
// ----------------------------------------------------------------------------
module mnd_divider import mnd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DIV_W-1:0]   num,
    input  logic [DIV_W-1:0]   den,
    output logic [DIV_Q_W-1:0] quot,
    output logic               ovf
);

    logic [DIV_W-1:0]   rem_reg [DIV_Q_W];
    logic [DIV_W-1:0]   den_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0] q_reg   [DIV_Q_W];
    logic [DIV_LAT-1:0] ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            ovf_reg    <= {ovf_reg[DIV_LAT-2:0], (num >= (den << DIV_Q_W))};
        end
    end

    for (genvar k = 1; k <= DIV_Q_W; k++)
    begin : g_bit
        localparam int BIT = DIV_Q_W - k;
        logic [DIV_W-1:0]   trial;
        logic [DIV_Q_W-1:0] q_in;
        logic               take;

        if (k == 1)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_next
            assign q_in = q_reg[k-2];
        end

        assign trial = den_reg[k-1] << BIT;
        assign take  = (trial <= rem_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k-1] <= take ? (q_in | (DIV_Q_W'(1) << BIT)) : q_in;
            end
        end

        if (k < DIV_Q_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quot = q_reg[DIV_Q_W-1];
    assign ovf  = ovf_reg[DIV_LAT-1];

endmodule

// ----- design/miyamoto_nagai_disk_force_core.sv -----
// ----------------------------------------------------------------------------
// miyamoto_nagai_disk_force_core
// throughput: one particle per cycle when not stalled, set by the fully
//   pipelined square root and divider units; skipped particles leave a
//   bubble and give no beat
// reset: clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module miyamoto_nagai_disk_force_core import mnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              particle_valid,
    output logic              particle_stall,
    input  particle_t         particle,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef struct packed {
        logic x_pos;
        logic y_pos;
        logic z_pos;
        logic dz_zero;
    } flag_t;

    typedef struct packed {
        logic [31:0] tag;
        flag_t       flags;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
    } sa_t;

    typedef struct packed {
        logic [31:0] tag;
        flag_t       flags;
        logic [63:0] ax2;
        logic [63:0] ay2;
        logic [63:0] az2;
        logic [63:0] nxl;
        logic [63:0] nyl;
        logic [63:0] nzl;
        logic [51:0] nxh;
        logic [51:0] nyh;
        logic [51:0] nzh;
    } sb_t;

    typedef struct packed {
        logic [31:0] tag;
        flag_t       flags;
        logic [64:0] xy;
        logic [83:0] nx;
        logic [83:0] ny;
        logic [83:0] nz;
    } side1_t;

    typedef struct packed {
        logic [31:0] tag;
        flag_t       flags;
        logic [83:0] nx;
        logic [83:0] ny;
        logic [83:0] nz;
        logic [33:0] ab;
        logic [32:0] zb;
    } side2_t;

    typedef struct packed {
        side2_t      s;
        logic [64:0] xy;
        logic [63:0] lo2;
        logic [33:0] mid;
        logic [3:0]  hi2;
    } se_t;

    typedef struct packed {
        side2_t      s;
        logic [34:0] dn;
        logic [63:0] ll;
        logic [34:0] hl;
        logic [5:0]  hh;
    } sg_t;

    typedef struct packed {
        side2_t      s;
        logic [34:0] dn;
        logic [69:0] dn2;
    } sh_t;

    typedef struct packed {
        side2_t      s;
        logic [34:0] dn;
        logic [63:0] p00;
        logic [63:0] p10;
        logic [37:0] p20;
        logic [34:0] p01;
        logic [34:0] p11;
        logic [8:0]  p21;
    } si_t;

    typedef struct packed {
        side2_t       s;
        logic [34:0]  dn;
        logic [102:0] s_lo;
        logic [73:0]  s_hi;
    } sj_t;

    typedef struct packed {
        side2_t       s;
        logic [34:0]  dn;
        logic [104:0] dn3;
    } sk_t;

    typedef struct packed {
        logic [31:0] tag;
        flag_t       flags;
        logic [33:0] ab;
        logic [32:0] zb;
        logic        dn_zero;
    } side3_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] acc_x;
        logic [31:0] acc_y;
        logic [31:0] pot;
        logic        z_pos;
        logic        z_zero;
    } side4_t;

    typedef struct packed {
        side4_t      s;
        logic [32:0] zb;
        logic [63:0] tl;
        logic [33:0] th;
    } sl_t;

    typedef struct packed {
        side4_t      s;
        logic [32:0] zb;
        logic [65:0] n2;
    } sm_t;

    // configuration registers
    logic [30:0]        a_reg;
    logic [30:0]        b_reg;
    logic [30:0]        m_reg;
    logic [20:0]        amp_reg;
    logic [31:0]        cx_reg;
    logic [31:0]        cy_reg;
    logic [31:0]        cz_reg;
    logic [4:0]         lvl_reg;
    logic [51:0]        am_reg;
    logic [61:0]        bsq_reg;

    logic               en;
    logic               cfg_wr;

    // pipeline registers
    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic               vg_reg, vh_reg, vi_reg, vj_reg, vk_reg, vl_reg, vm_reg, vn_reg;
    logic [SQRT_LAT-1:0] v1_reg;
    logic [SQRT_LAT-1:0] v2_reg;
    logic [DIV_LAT-1:0]  v3_reg;
    logic [DIV_LAT-1:0]  v4_reg;

    sa_t                sa_reg;
    sb_t                sb_reg;
    side1_t             sc_side_reg;
    logic [64:0]        sc_zsum_reg;
    side1_t             s1_reg [SQRT_LAT];
    se_t                sd_reg;
    se_t                se_reg;
    side2_t             sf_side_reg;
    logic [69:0]        sf_d2_reg;
    side2_t             s2_reg [SQRT_LAT];
    sg_t                sg_reg;
    sh_t                sh_reg;
    si_t                si_reg;
    sj_t                sj_reg;
    sk_t                sk_reg;
    side3_t             s3_reg [DIV_LAT];
    sl_t                sl_reg;
    sm_t                sm_reg;
    side4_t             s4_reg [DIV_LAT];
    result_t            sn_reg;

    logic               result_valid_reg;
    result_t            result_reg;

    // stage a inputs
    logic [32:0]        dx, dy, dz;
    sa_t                sa_next;

    logic [SQRT_OUT_W-1:0] zb_root;
    logic [SQRT_OUT_W-1:0] dn_root;

    logic [DIV_Q_W-1:0] qx, qy, qz, qp, q2;
    logic               ovfx, ovfy, ovfz, ovfp, ovf2;

    side3_t             s3_in;
    side3_t             s3_out;
    side4_t             s4_out;
    logic [31:0]        t_clamp;
    sl_t                sl_next;
    logic               dn_zero_l;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= 31'd1048576;
            b_reg   <= 31'd104858;
            m_reg   <= 31'd1048576;
            amp_reg <= 21'd1048576;
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            lvl_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[ADDR_W-1:2])
                REG_SCALE_LENGTH: a_reg   <= pwdata[30:0];
                REG_SCALE_HEIGHT: b_reg   <= pwdata[30:0];
                REG_DISK_MASS:    m_reg   <= pwdata[30:0];
                REG_AMPLITUDE:    amp_reg <= pwdata[20:0];
                REG_CENTER_X:     cx_reg  <= pwdata;
                REG_CENTER_Y:     cy_reg  <= pwdata;
                REG_CENTER_Z:     cz_reg  <= pwdata;
                REG_MIN_LEVEL:    lvl_reg <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_SCALE_LENGTH: prdata = {1'b0, a_reg};
            REG_SCALE_HEIGHT: prdata = {1'b0, b_reg};
            REG_DISK_MASS:    prdata = {1'b0, m_reg};
            REG_AMPLITUDE:    prdata = {11'd0, amp_reg};
            REG_CENTER_X:     prdata = cx_reg;
            REG_CENTER_Y:     prdata = cy_reg;
            REG_CENTER_Z:     prdata = cz_reg;
            REG_MIN_LEVEL:    prdata = {27'd0, lvl_reg};
            default:          prdata = '0;
        endcase
    end

    // derived constants
    always_ff @(posedge clk)
    begin
        am_reg  <= 52'(amp_reg) * 52'(m_reg);
        bsq_reg <= 62'(b_reg) * 62'(b_reg);
    end

    // ------------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------------
    assign en             = !(result_valid_reg && result_stall && vn_reg);
    assign particle_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            v1_reg <= '0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            v2_reg <= '0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
            v3_reg <= '0;
            vl_reg <= 1'b0;
            vm_reg <= 1'b0;
            v4_reg <= '0;
            vn_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= particle_valid && (particle.step_level >= lvl_reg);
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            v1_reg <= {v1_reg[SQRT_LAT-2:0], vc_reg};
            vd_reg <= v1_reg[SQRT_LAT-1];
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            v2_reg <= {v2_reg[SQRT_LAT-2:0], vf_reg};
            vg_reg <= v2_reg[SQRT_LAT-1];
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
            vk_reg <= vj_reg;
            v3_reg <= {v3_reg[DIV_LAT-2:0], vk_reg};
            vl_reg <= v3_reg[DIV_LAT-1];
            vm_reg <= vl_reg;
            v4_reg <= {v4_reg[DIV_LAT-2:0], vm_reg};
            vn_reg <= v4_reg[DIV_LAT-1];
        end
    end

    // ------------------------------------------------------------------------
    // a: offsets from center
    // ------------------------------------------------------------------------
    assign dx = {particle.pos_x[31], particle.pos_x} - {cx_reg[31], cx_reg};
    assign dy = {particle.pos_y[31], particle.pos_y} - {cy_reg[31], cy_reg};
    assign dz = {particle.pos_z[31], particle.pos_z} - {cz_reg[31], cz_reg};

    always_comb
    begin
        sa_next.tag           = particle.particle_tag;
        sa_next.flags.x_pos   = !dx[32] && (dx != '0);
        sa_next.flags.y_pos   = !dy[32] && (dy != '0);
        sa_next.flags.z_pos   = !dz[32] && (dz != '0);
        sa_next.flags.dz_zero = (dz == '0);
        sa_next.ax            = dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        sa_next.ay            = dy[32] ? 32'(33'd0 - dy) : dy[31:0];
        sa_next.az            = dz[32] ? 32'(33'd0 - dz) : dz[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg <= sa_next;

            // b: squares and amplitude-mass products
            sb_reg.tag   <= sa_reg.tag;
            sb_reg.flags <= sa_reg.flags;
            sb_reg.ax2   <= 64'(sa_reg.ax) * 64'(sa_reg.ax);
            sb_reg.ay2   <= 64'(sa_reg.ay) * 64'(sa_reg.ay);
            sb_reg.az2   <= 64'(sa_reg.az) * 64'(sa_reg.az);
            sb_reg.nxl   <= 64'(am_reg[31:0]) * 64'(sa_reg.ax);
            sb_reg.nyl   <= 64'(am_reg[31:0]) * 64'(sa_reg.ay);
            sb_reg.nzl   <= 64'(am_reg[31:0]) * 64'(sa_reg.az);
            sb_reg.nxh   <= 52'(am_reg[51:32]) * 52'(sa_reg.ax);
            sb_reg.nyh   <= 52'(am_reg[51:32]) * 52'(sa_reg.ay);
            sb_reg.nzh   <= 52'(am_reg[51:32]) * 52'(sa_reg.az);

            // c: sums
            sc_side_reg.tag   <= sb_reg.tag;
            sc_side_reg.flags <= sb_reg.flags;
            sc_side_reg.xy    <= 65'(sb_reg.ax2) + 65'(sb_reg.ay2);
            sc_side_reg.nx    <= 84'(sb_reg.nxl) + (84'(sb_reg.nxh) << 32);
            sc_side_reg.ny    <= 84'(sb_reg.nyl) + (84'(sb_reg.nyh) << 32);
            sc_side_reg.nz    <= 84'(sb_reg.nzl) + (84'(sb_reg.nzh) << 32);
            sc_zsum_reg       <= 65'(sb_reg.az2) + 65'(bsq_reg);

            s1_reg[0] <= sc_side_reg;
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                s1_reg[i] <= s1_reg[i-1];
            end
        end
    end

    // zb = sqrt(dz^2 + b^2)
    mnd_isqrt u_sqrt_zb
    (
        .clk      (clk),
        .en       (en),
        .radicand (SQRT_IN_W'(sc_zsum_reg)),
        .root     (zb_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // d: a + zb
            sd_reg.s.tag   <= s1_reg[SQRT_LAT-1].tag;
            sd_reg.s.flags <= s1_reg[SQRT_LAT-1].flags;
            sd_reg.s.nx    <= s1_reg[SQRT_LAT-1].nx;
            sd_reg.s.ny    <= s1_reg[SQRT_LAT-1].ny;
            sd_reg.s.nz    <= s1_reg[SQRT_LAT-1].nz;
            sd_reg.s.zb    <= zb_root[32:0];
            sd_reg.s.ab    <= 34'(a_reg) + 34'(zb_root[32:0]);
            sd_reg.xy      <= s1_reg[SQRT_LAT-1].xy;
            sd_reg.lo2     <= '0;
            sd_reg.mid     <= '0;
            sd_reg.hi2     <= '0;

            // e: (a + zb)^2 partial products
            se_reg.s   <= sd_reg.s;
            se_reg.xy  <= sd_reg.xy;
            se_reg.lo2 <= 64'(sd_reg.s.ab[31:0]) * 64'(sd_reg.s.ab[31:0]);
            se_reg.mid <= 34'(sd_reg.s.ab[33:32]) * 34'(sd_reg.s.ab[31:0]);
            se_reg.hi2 <= 4'(sd_reg.s.ab[33:32]) * 4'(sd_reg.s.ab[33:32]);

            // f: squared distance
            sf_side_reg <= se_reg.s;
            sf_d2_reg   <= 70'(se_reg.xy) + 70'(se_reg.lo2) + (70'(se_reg.mid) << 33)
                           + (70'(se_reg.hi2) << 64);

            s2_reg[0] <= sf_side_reg;
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                s2_reg[i] <= s2_reg[i-1];
            end
        end
    end

    // dn = sqrt(R^2 + (a + zb)^2)
    mnd_isqrt u_sqrt_dn
    (
        .clk      (clk),
        .en       (en),
        .radicand (sf_d2_reg),
        .root     (dn_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // g: dn^2 partial products
            sg_reg.s  <= s2_reg[SQRT_LAT-1];
            sg_reg.dn <= dn_root;
            sg_reg.ll <= 64'(dn_root[31:0]) * 64'(dn_root[31:0]);
            sg_reg.hl <= 35'(dn_root[34:32]) * 35'(dn_root[31:0]);
            sg_reg.hh <= 6'(dn_root[34:32]) * 6'(dn_root[34:32]);

            // h: dn^2
            sh_reg.s   <= sg_reg.s;
            sh_reg.dn  <= sg_reg.dn;
            sh_reg.dn2 <= 70'(sg_reg.ll) + (70'(sg_reg.hl) << 33) + (70'(sg_reg.hh) << 64);

            // i: dn^3 partial products
            si_reg.s   <= sh_reg.s;
            si_reg.dn  <= sh_reg.dn;
            si_reg.p00 <= 64'(sh_reg.dn2[31:0]) * 64'(sh_reg.dn[31:0]);
            si_reg.p10 <= 64'(sh_reg.dn2[63:32]) * 64'(sh_reg.dn[31:0]);
            si_reg.p20 <= 38'(sh_reg.dn2[69:64]) * 38'(sh_reg.dn[31:0]);
            si_reg.p01 <= 35'(sh_reg.dn2[31:0]) * 35'(sh_reg.dn[34:32]);
            si_reg.p11 <= 35'(sh_reg.dn2[63:32]) * 35'(sh_reg.dn[34:32]);
            si_reg.p21 <= 9'(sh_reg.dn2[69:64]) * 9'(sh_reg.dn[34:32]);

            // j: partial sums
            sj_reg.s    <= si_reg.s;
            sj_reg.dn   <= si_reg.dn;
            sj_reg.s_lo <= 103'(si_reg.p00) + (103'(si_reg.p10) << 32)
                           + (103'(si_reg.p20) << 64);
            sj_reg.s_hi <= 74'(si_reg.p01) + (74'(si_reg.p11) << 32)
                           + (74'(si_reg.p21) << 64);

            // k: dn^3
            sk_reg.s   <= sj_reg.s;
            sk_reg.dn  <= sj_reg.dn;
            sk_reg.dn3 <= 105'(sj_reg.s_lo) + (105'(sj_reg.s_hi) << 32);

            s3_reg[0] <= s3_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                s3_reg[i] <= s3_reg[i-1];
            end
        end
    end

    always_comb
    begin
        s3_in.tag     = sk_reg.s.tag;
        s3_in.flags   = sk_reg.s.flags;
        s3_in.ab      = sk_reg.s.ab;
        s3_in.zb      = sk_reg.s.zb;
        s3_in.dn_zero = (sk_reg.dn == '0);
    end

    mnd_divider u_div_x
    (
        .clk  (clk),
        .en   (en),
        .num  (DIV_W'({sk_reg.s.nx, 20'd0})),
        .den  (DIV_W'(sk_reg.dn3)),
        .quot (qx),
        .ovf  (ovfx)
    );

    mnd_divider u_div_y
    (
        .clk  (clk),
        .en   (en),
        .num  (DIV_W'({sk_reg.s.ny, 20'd0})),
        .den  (DIV_W'(sk_reg.dn3)),
        .quot (qy),
        .ovf  (ovfy)
    );

    mnd_divider u_div_z
    (
        .clk  (clk),
        .en   (en),
        .num  (DIV_W'({sk_reg.s.nz, 20'd0})),
        .den  (DIV_W'(sk_reg.dn3)),
        .quot (qz),
        .ovf  (ovfz)
    );

    mnd_divider u_div_pot
    (
        .clk  (clk),
        .en   (en),
        .num  (DIV_W'({m_reg, 20'd0})),
        .den  (DIV_W'(sk_reg.dn)),
        .quot (qp),
        .ovf  (ovfp)
    );

    // ------------------------------------------------------------------------
    // l: x, y, potential results and the z correction product
    // ------------------------------------------------------------------------
    assign s3_out    = s3_reg[DIV_LAT-1];
    assign dn_zero_l = s3_out.dn_zero;
    assign t_clamp   = ovfz ? 32'h8000_0000 : {1'b0, qz};

    always_comb
    begin
        sl_next.s.tag    = s3_out.tag;
        sl_next.s.acc_x  = dn_zero_l ? 32'd0 : sat_mag(qx, ovfx, s3_out.flags.x_pos);
        sl_next.s.acc_y  = dn_zero_l ? 32'd0 : sat_mag(qy, ovfy, s3_out.flags.y_pos);
        if (dn_zero_l)
        begin
            sl_next.s.pot = (m_reg != '0) ? 32'h8000_0000 : 32'd0;
        end
        else
        begin
            sl_next.s.pot = sat_mag(qp, ovfp, 1'b1);
        end
        sl_next.s.z_pos  = s3_out.flags.z_pos;
        sl_next.s.z_zero = s3_out.flags.dz_zero || (s3_out.zb == '0) || dn_zero_l;
        sl_next.zb       = s3_out.zb;
        sl_next.tl       = 64'(t_clamp) * 64'(s3_out.ab[31:0]);
        sl_next.th       = 34'(t_clamp) * 34'(s3_out.ab[33:32]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_reg <= sl_next;

            // m: t * (a + zb)
            sm_reg.s  <= sl_reg.s;
            sm_reg.zb <= sl_reg.zb;
            sm_reg.n2 <= 66'(sl_reg.tl) + (66'(sl_reg.th) << 32);

            s4_reg[0] <= sm_reg.s;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                s4_reg[i] <= s4_reg[i-1];
            end

            // n: final z
            sn_reg.tag_out   <= s4_out.tag;
            sn_reg.acc_x     <= s4_out.acc_x;
            sn_reg.acc_y     <= s4_out.acc_y;
            sn_reg.potential <= s4_out.pot;
            sn_reg.acc_z     <= s4_out.z_zero ? 32'd0 : sat_mag(q2, ovf2, s4_out.z_pos);
        end
    end

    assign s4_out = s4_reg[DIV_LAT-1];

    mnd_divider u_div_zb
    (
        .clk  (clk),
        .en   (en),
        .num  (DIV_W'(sm_reg.n2)),
        .den  (DIV_W'(sm_reg.zb)),
        .quot (q2),
        .ovf  (ovf2)
    );

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || !result_stall)
        begin
            result_valid_reg <= vn_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || !result_stall)
        begin
            result_reg <= sn_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- test/mnd_force_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mnd_force_checker
// Watches the particle, result and register ports of the disk force core.
// It keeps its own copy of the registers and computes the expected
// acceleration and potential for each accepted particle with exact wide
// integer arithmetic. Each result beat is then compared field by field
// with the oldest expected result.
// ----------------------------------------------------------------------------
module mnd_force_checker import mnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              particle_valid,
    input  logic              particle_stall,
    input  particle_t         particle,
    input  logic              result_valid,
    input  logic              result_stall,
    input  result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                errors,
    output int                pending
);

    logic [30:0]        len_a;
    logic [30:0]        hgt_b;
    logic [30:0]        mass;
    logic [20:0]        amp;
    logic signed [31:0] ctr_x;
    logic signed [31:0] ctr_y;
    logic signed [31:0] ctr_z;
    logic [4:0]         lvl_min;

    result_t force_q[$];

    assign pending = force_q.size();

    function automatic logic [255:0] isqrt(input logic [255:0] n);
        logic [255:0] res;
        logic [255:0] cand;
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = res | (256'd1 << i);
            if (cand * cand <= n)
            begin
                res = cand;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_q20(input logic [255:0] q, input logic neg);
        if (neg)
        begin
            return (q >= 256'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return (q >= 256'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic logic signed [33:0] offset(input logic signed [31:0] p,
                                                  input logic signed [31:0] c);
        return 34'(p) - 34'(c);
    endfunction

    function automatic logic [255:0] magn(input logic signed [33:0] v);
        logic [33:0] m;
        m = (v < 0) ? -v : v;
        return 256'(m);
    endfunction

    function automatic result_t disk_force(input particle_t p);
        result_t r;
        logic signed [33:0] dx, dy, dz;
        logic [255:0] ax, ay, az, zb, ab, dn, dn3, am, q;
        dx = offset(p.pos_x, ctr_x);
        dy = offset(p.pos_y, ctr_y);
        dz = offset(p.pos_z, ctr_z);
        ax = magn(dx);
        ay = magn(dy);
        az = magn(dz);
        zb = isqrt(az * az + 256'(hgt_b) * 256'(hgt_b));
        ab = 256'(len_a) + zb;
        dn = isqrt(ax * ax + ay * ay + ab * ab);
        r.tag_out = p.particle_tag;
        if (dn == 0)
        begin
            r.acc_x = '0;
            r.acc_y = '0;
            r.acc_z = '0;
            r.potential = (mass != 0) ? 32'h8000_0000 : 32'd0;
            return r;
        end
        r.potential = sat_q20((256'(mass) << 20) / dn, 1'b1);
        am = 256'(amp) * 256'(mass);
        dn3 = dn * dn * dn;
        r.acc_x = sat_q20(((am * ax) << 20) / dn3, dx > 0);
        r.acc_y = sat_q20(((am * ay) << 20) / dn3, dy > 0);
        if (zb == 0 || dz == 0)
        begin
            r.acc_z = '0;
        end
        else
        begin
            q = ((am * az) << 20) / dn3;
            if (q > 256'h8000_0000)
            begin
                q = 256'h8000_0000;
            end
            r.acc_z = sat_q20((q * ab) / zb, dz > 0);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            len_a   <= 31'd1048576;
            hgt_b   <= 31'd104858;
            mass    <= 31'd1048576;
            amp     <= 21'd1048576;
            ctr_x   <= '0;
            ctr_y   <= '0;
            ctr_z   <= '0;
            lvl_min <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SCALE_LENGTH: len_a   <= pwdata[30:0];
                    REG_SCALE_HEIGHT: hgt_b   <= pwdata[30:0];
                    REG_DISK_MASS:    mass    <= pwdata[30:0];
                    REG_AMPLITUDE:    amp     <= pwdata[20:0];
                    REG_CENTER_X:     ctr_x   <= pwdata;
                    REG_CENTER_Y:     ctr_y   <= pwdata;
                    REG_CENTER_Z:     ctr_z   <= pwdata;
                    REG_MIN_LEVEL:    lvl_min <= pwdata[4:0];
                    default: ;
                endcase
            end
            if (particle_valid && !particle_stall && particle.step_level >= lvl_min)
            begin
                force_q.push_back(disk_force(particle));
            end
            if (result_valid && !result_stall)
            begin
                if (force_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t unexpected result beat tag %h", $realtime, result.tag_out);
                    end
                end
                else
                begin
                    want = force_q.pop_front();
                    check_field("tag_out", want.tag_out, result.tag_out);
                    check_field("acc_x", want.acc_x, result.acc_x);
                    check_field("acc_y", want.acc_y, result.acc_y);
                    check_field("acc_z", want.acc_z, result.acc_z);
                    check_field("potential", want.potential, result.potential);
                end
            end
        end
    end

    initial
    begin
        errors = 0;
    end

endmodule

// ----- test/tb_miyamoto_nagai_disk_force_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miyamoto_nagai_disk_force_core
// Drives particles and register writes into the disk force core: a directed
// set of corner particles, then random phases over several register settings
// and idle/stall mixes. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_miyamoto_nagai_disk_force_core;
    import mnd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [31:0] Q_ONE = 32'd1048576;

    logic              clk;
    logic              rst_n;
    logic              particle_valid;
    logic              particle_stall;
    particle_t         particle;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int errors;
    int pending;
    int cycles;
    int send_idle_pct;
    int stall_pct;
    logic [31:0] cx, cy, cz;

    miyamoto_nagai_disk_force_core DUT (.*);

    mnd_force_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        result_stall <= ($urandom_range(99) < stall_pct);
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        particle_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_beat(input logic [31:0] tag, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [4:0] lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            particle_valid <= 1'b0;
            @(posedge clk);
        end
        particle_valid <= 1'b1;
        particle <= '{particle_tag: tag, pos_x: px, pos_y: py, pos_z: pz, step_level: lvl};
        @(posedge clk);
        while (particle_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_disk(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] m, input logic [31:0] w,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [4:0] lvl);
        reg_write(REG_SCALE_LENGTH, a);
        reg_write(REG_SCALE_HEIGHT, b);
        reg_write(REG_DISK_MASS, m);
        reg_write(REG_AMPLITUDE, w);
        reg_write(REG_CENTER_X, x);
        reg_write(REG_CENTER_Y, y);
        reg_write(REG_CENTER_Z, z);
        reg_write(REG_MIN_LEVEL, 32'(lvl));
        cx = x;
        cy = y;
        cz = z;
    endtask

    function automatic logic [31:0] near(input logic [31:0] c);
        if ($urandom_range(99) < 70)
        begin
            return c + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        end
        return $urandom;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        particle_valid = 1'b0;
        particle = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cx = '0;
        cy = '0;
        cz = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner particles with the reset disk
        send_beat(32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
        send_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd31);
        send_beat(32'h5555_AAAA, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd10);
        send_beat(32'h1, 32'h0, 32'h0, Q_ONE, 5'd1);
        send_beat(32'h2, Q_ONE, 32'h0, 32'h0, 5'd2);
        send_beat(32'h3, 32'hFFF0_0000, Q_ONE, 32'hFFF8_0000, 5'd3);
        drain();

        // collapsed disk: zero height, zero length, full mass, amplitude above one
        load_disk(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1F_FFFF, 32'h0, 32'h0, 32'h0, 5'd0);
        send_beat(32'h10, 32'h0, 32'h0, 32'h0, 5'd0);
        send_beat(32'h11, 32'h0, 32'h0, 32'h1, 5'd0);
        send_beat(32'h12, Q_ONE, 32'h0, 32'h0, 5'd0);
        send_beat(32'h13, 32'h3, 32'hFFFF_FFFD, 32'h0, 5'd0);
        drain();
        reg_write(REG_DISK_MASS, 32'h0);
        send_beat(32'h14, 32'h0, 32'h0, 32'h0, 5'd0);
        send_beat(32'h15, Q_ONE, Q_ONE, Q_ONE, 5'd7);
        drain();

        // level threshold and extreme centers
        load_disk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, Q_ONE,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5'd5);
        send_beat(32'h20, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5'd4);
        send_beat(32'h21, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5'd5);
        send_beat(32'h22, 32'h0, 32'h0, 32'h0, 5'd0);
        send_beat(32'h23, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5'd31);
        drain();
        reg_write(REG_MIN_LEVEL, 32'd31);
        send_beat(32'h24, Q_ONE, Q_ONE, Q_ONE, 5'd30);
        send_beat(32'h25, Q_ONE, Q_ONE, Q_ONE, 5'd31);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_disk(Q_ONE, 32'd104858, Q_ONE, Q_ONE, 0, 0, 0, 5'd0);
                1: load_disk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1F_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5'd16);
                2: load_disk(32'h1, 32'h0, 32'h0, 32'h0,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd0);
                3: load_disk(32'h1, 32'h0, 32'h7FFF_FFFF, Q_ONE, 0, 0, 0, 5'd0);
                default: load_disk($urandom_range(32'h2_0000, 32'h40_0000),
                                   $urandom_range(0, 32'h20_0000), $urandom_range(0, 32'h7FFF_FFFF),
                                   $urandom_range(0, Q_ONE),
                                   $urandom_range(0, 32'h0800_0000) - 32'h0400_0000,
                                   $urandom_range(0, 32'h0800_0000) - 32'h0400_0000,
                                   $urandom_range(0, 32'h0800_0000) - 32'h0400_0000,
                                   5'($urandom_range(0, 3)));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < 165; n++)
            begin
                send_beat($urandom, near(cx), near(cy), near(cz), 5'($urandom_range(0, 31)));
            end
            drain();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
